// File: rtl/core/assert_macros.svh
// Assertion macros shared by the active list RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property checked on every clock edge outside reset.
`define ALCR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Property checked on every clock edge, reset included.
`define ALCR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// File: rtl/core/alcr_pkg.sv
// Package with the shared types and codes of the active list.
package alcr_pkg;
  localparam int unsigned PcW = 32;
  localparam int unsigned ValW = 64;
  localparam int unsigned LimW = 3;
  localparam int unsigned KindW = 3;

  localparam logic [1:0] CmdDispatch = 2'd0;
  localparam logic [1:0] CmdForward = 2'd1;
  localparam logic [1:0] CmdCommit = 2'd2;
  localparam logic [1:0] CmdRollback = 2'd3;

  localparam logic [KindW-1:0] KindNone = 3'd0;
  localparam logic [KindW-1:0] KindFree = 3'd1;
  localparam logic [KindW-1:0] KindRestore = 3'd2;
  localparam logic [KindW-1:0] KindWrite = 3'd3;
  localparam logic [KindW-1:0] KindExc = 3'd4;
  localparam logic [KindW-1:0] KindExcClr = 3'd5;
  localparam logic [KindW-1:0] KindFull = 3'd6;
  localparam logic [KindW-1:0] KindMisuse = 3'd7;

  localparam logic [0:0] RegCommitLimit = 1'd0;
  localparam logic [0:0] RegExcVector = 1'd1;

  // Control from the sequencer to every cell of the chain.
  typedef struct packed {
    logic shift_in;   // move each entry one place towards the tail
    logic shift_out;  // move each entry one place towards the head
    logic fwd;        // forward match strobe
    logic fwd_fault;
  } cell_ctrl_t;
endpackage

// File: rtl/core/alcr_if.sv
// Valid/ready channel interface carrying a payload of a given type.
interface alcr_if #(parameter type payload_t = logic) ();
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/alcr_cell.sv
// One active list entry: holds its fields and passes them along the chain.
module alcr_cell #(
  parameter int unsigned PhysW = 6,
  parameter int unsigned LogW = 5
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  alcr_pkg::cell_ctrl_t ctrl_i,
  input  logic [alcr_pkg::PcW-1:0] fwd_pc_i,
  input  logic [alcr_pkg::PcW+LogW+2*PhysW+1:0] tail_side_i,
  input  logic [alcr_pkg::PcW+LogW+2*PhysW+1:0] head_side_i,
  output logic [alcr_pkg::PcW+LogW+2*PhysW+1:0] entry_o
);
  localparam int unsigned EW = alcr_pkg::PcW + LogW + 2*PhysW + 2;
  logic [EW-1:0] entry_q, entry_d;

  // Entry layout: pc, logical, prior, fresh, done, fault.
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.shift_in) begin
      entry_d = head_side_i;
    end else if (ctrl_i.shift_out) begin
      entry_d = tail_side_i;
    end else if (ctrl_i.fwd && entry_q[EW-1 -: alcr_pkg::PcW] == fwd_pc_i) begin
      entry_d[1] = 1'b1;
      entry_d[0] = ctrl_i.fwd_fault;
    end
  end

  // The entry register starts cleared.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;
endmodule

// File: rtl/core/active_list_commit_rollback.sv
// Active list top level: cell chain, sequencer, result register, APB port.
// A dispatch writes its result into the result register on acceptance; a forward, commit
// or rollback first moves to the run state, which writes its results one at a time.
// No new command is taken until the sequencer is idle and the single result register
// is empty: that register holds the input off.
// Reset clears occupancy, exception mode, every cell and the registers (limit 4, vector 0).
`include "assert_macros.svh"
module active_list_commit_rollback #(
  parameter int unsigned LIST_DEPTH = 32,
  parameter int unsigned COMMIT_WIDTH = 4,
  parameter int unsigned PHYS_REGS = 64,
  parameter int unsigned LOGICAL_REGS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  alcr_if.sink in_if,
  alcr_if.source out_if,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  localparam int unsigned PhysW = 6;
  localparam int unsigned LogW = 5;
  localparam int unsigned EW = alcr_pkg::PcW + LogW + 2*PhysW + 2;
  localparam int unsigned OccW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned IdxW = $clog2(LIST_DEPTH);
  localparam int unsigned CntW = 3;
  localparam int unsigned MaxRes = (COMMIT_WIDTH < 4) ? COMMIT_WIDTH : 4;

  // Config registers.
  logic [alcr_pkg::LimW-1:0] limit_q;
  logic [31:0] vector_q;
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 3'd4;
      vector_q <= '0;
    end else if (cfg_wr && paddr[1:0] == 2'b00) begin
      if (paddr[2] == alcr_pkg::RegCommitLimit) limit_q <= pwdata[2:0];
      else vector_q <= pwdata;
    end
  end
  always_comb begin
    if (paddr[2] == alcr_pkg::RegCommitLimit) prdata = {29'd0, limit_q};
    else prdata = vector_q;
  end

  // Chain: cell 0 holds the youngest entry and cell occ-1 the oldest. A dispatch
  // shifts every entry one cell along and a rollback shifts them back.
  logic [EW-1:0] ent [LIST_DEPTH];
  logic [EW-1:0] new_entry;
  alcr_pkg::cell_ctrl_t ctrl;
  logic [alcr_pkg::PcW-1:0] pc_q, pc_d;

  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
    logic [EW-1:0] hs, ts;
    if (g == 0) begin : g_h
      assign hs = new_entry;
    end else begin : g_m
      assign hs = ent[g-1];
    end
    if (g == LIST_DEPTH-1) begin : g_t
      assign ts = '0;
    end else begin : g_n
      assign ts = ent[g+1];
    end
    alcr_cell #(.PhysW(PhysW), .LogW(LogW)) u_cell (
      .clk_i, .rst_ni, .ctrl_i(ctrl), .fwd_pc_i(pc_q),
      .tail_side_i(ts), .head_side_i(hs), .entry_o(ent[g]));
  end

  // Sequencer state.
  typedef enum logic {StIdle, StRun} st_e;
  st_e st_q, st_d;
  logic [OccW-1:0] occ_q, occ_d;
  logic exc_q, exc_d;
  logic [1:0] cmd_q, cmd_d;
  logic [PhysW-1:0] fresh_q, fresh_d;
  logic fault_q, fault_d;
  logic [alcr_pkg::ValW-1:0] val_q, val_d;
  logic [CntW-1:0] n_q, n_d, lim_q, lim_d;
  logic [EW-1:0] oldest;
  logic next_done;

  typedef struct packed {
    logic [alcr_pkg::KindW-1:0] kind;
    logic [PhysW-1:0] phys_reg;
    logic [LogW-1:0] logical_reg;
    logic [PhysW-1:0] restored_phys;
    logic [alcr_pkg::ValW-1:0] write_value;
    logic [alcr_pkg::PcW-1:0] fault_pc;
    logic [alcr_pkg::PcW-1:0] redirect_pc;
    logic last;
  } res_t;
  res_t res_q, res_d;
  logic ov_q, ov_d;

  // Oldest entry sits at cell occ-1: a mux over cells (read for commit).
  always_comb begin
    oldest = ent[0];
    for (int k = 0; k < LIST_DEPTH; k++) begin
      if (occ_q == OccW'(k+1)) oldest = ent[k];
    end
  end

  // Done flag of the entry just younger than the oldest.
  assign next_done = ent[IdxW'(occ_q - OccW'(2))][1];

  assign new_entry = {in_if.data.instr_pc, in_if.data.logical_dest,
                      in_if.data.prior_phys, in_if.data.fresh_phys, 2'b00};

  logic acc;
  assign in_if.ready = (st_q == StIdle) && !ov_q;
  assign acc = in_if.valid && in_if.ready;

  logic disp_bad, disp_room, disp_ok;
  assign disp_bad = exc_q || !(32'(in_if.data.logical_dest) < LOGICAL_REGS &&
                               32'(in_if.data.prior_phys) < PHYS_REGS &&
                               32'(in_if.data.fresh_phys) < PHYS_REGS);
  assign disp_room = 32'(occ_q) < LIST_DEPTH;
  assign disp_ok = acc && in_if.data.command == alcr_pkg::CmdDispatch && !disp_bad &&
                   disp_room;

  always_comb begin
    ctrl = '0;
    ctrl.shift_in = disp_ok;
    ctrl.fwd = (st_q == StRun) && cmd_q == alcr_pkg::CmdForward && !ov_q &&
               32'(fresh_q) < PHYS_REGS;
    ctrl.fwd_fault = fault_q;
    // Rollback pops the youngest entry at cell 0.
    ctrl.shift_out = (st_q == StRun) && cmd_q == alcr_pkg::CmdRollback && exc_q &&
                     occ_q != '0 && !ov_q;
  end

  // Forward match over occupied cells.
  logic hit;
  always_comb begin
    hit = 1'b0;
    for (int k = 0; k < LIST_DEPTH; k++) begin
      if (OccW'(k) < occ_q && ent[k][EW-1 -: alcr_pkg::PcW] == pc_q) hit = 1'b1;
    end
  end

  logic out_take;
  assign out_take = out_if.valid && out_if.ready;
  assign out_if.valid = ov_q;
  always_comb begin
    out_if.data = '0;
    out_if.data.kind = res_q.kind;
    out_if.data.phys_reg = res_q.phys_reg;
    out_if.data.logical_reg = res_q.logical_reg;
    out_if.data.restored_phys = res_q.restored_phys;
    out_if.data.write_value = res_q.write_value;
    out_if.data.fault_pc = res_q.fault_pc;
    out_if.data.redirect_pc = res_q.redirect_pc;
    out_if.data.last = res_q.last;
  end

  // Next state of the sequencer, one registered result per step.
  always_comb begin
    st_d = st_q;
    occ_d = occ_q;
    exc_d = exc_q;
    ov_d = ov_q;
    n_d = n_q;
    lim_d = lim_q;
    cmd_d = cmd_q;
    pc_d = pc_q;
    fresh_d = fresh_q;
    fault_d = fault_q;
    val_d = val_q;
    res_d = res_q;
    if (out_take) ov_d = 1'b0;
    unique case (st_q)
      StIdle: begin
        if (acc) begin
          cmd_d = in_if.data.command;
          pc_d = in_if.data.instr_pc;
          fresh_d = in_if.data.fresh_phys;
          fault_d = in_if.data.fault;
          val_d = in_if.data.result_value;
          n_d = '0;
          if (limit_q == '0) lim_d = CntW'(1);
          else if (32'(limit_q) > MaxRes) lim_d = CntW'(MaxRes);
          else lim_d = limit_q;
          if (in_if.data.command == alcr_pkg::CmdDispatch) begin
            res_d = '0;
            res_d.last = 1'b1;
            ov_d = 1'b1;
            if (disp_bad) res_d.kind = alcr_pkg::KindMisuse;
            else if (!disp_room) res_d.kind = alcr_pkg::KindFull;
            else begin
              res_d.kind = alcr_pkg::KindNone;
              occ_d = occ_q + OccW'(1);
            end
          end else begin
            st_d = StRun;
          end
        end
      end
      StRun: begin
        if (!ov_q) begin
          res_d = '0;
          res_d.last = 1'b1;
          ov_d = 1'b1;
          st_d = StIdle;
          case (cmd_q)
            alcr_pkg::CmdForward: begin
              if (!(32'(fresh_q) < PHYS_REGS)) res_d.kind = alcr_pkg::KindMisuse;
              else if (hit && !fault_q) begin
                res_d.kind = alcr_pkg::KindWrite;
                res_d.phys_reg = fresh_q;
                res_d.write_value = val_q;
              end else res_d.kind = alcr_pkg::KindNone;
            end
            alcr_pkg::CmdCommit: begin
              if (exc_q) res_d.kind = alcr_pkg::KindMisuse;
              else if (occ_q == '0 || !oldest[1]) begin
                if (n_q == '0) res_d.kind = alcr_pkg::KindNone;
                else ov_d = 1'b0;
              end else if (oldest[0]) begin
                exc_d = 1'b1;
                res_d.kind = alcr_pkg::KindExc;
                res_d.fault_pc = oldest[EW-1 -: alcr_pkg::PcW];
                res_d.redirect_pc = vector_q;
              end else begin
                res_d.kind = alcr_pkg::KindFree;
                res_d.phys_reg = oldest[2*PhysW+1 -: PhysW];
                occ_d = occ_q - OccW'(1);
                n_d = n_q + CntW'(1);
                // Look ahead so that the last beat of the command carries the flag.
                if (n_q + CntW'(1) < lim_q && occ_q > OccW'(1) && next_done) begin
                  res_d.last = 1'b0;
                  st_d = StRun;
                end
              end
            end
            // Rollback; a dispatch never reaches this state.
            default: begin
              if (!exc_q) res_d.kind = alcr_pkg::KindMisuse;
              else if (occ_q == '0) begin
                if (n_q == '0) begin
                  exc_d = 1'b0;
                  res_d.kind = alcr_pkg::KindExcClr;
                end else ov_d = 1'b0;
              end else begin
                res_d.kind = alcr_pkg::KindRestore;
                res_d.phys_reg = ent[0][PhysW+1 -: PhysW];
                res_d.logical_reg = ent[0][2*PhysW+LogW+1 -: LogW];
                res_d.restored_phys = ent[0][2*PhysW+1 -: PhysW];
                occ_d = occ_q - OccW'(1);
                n_d = n_q + CntW'(1);
                if (n_q + CntW'(1) < lim_q && occ_q > OccW'(1)) begin
                  res_d.last = 1'b0;
                  st_d = StRun;
                end
              end
            end
          endcase
        end
      end
    endcase
  end

  // Sequencer registers and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      occ_q <= '0;
      exc_q <= 1'b0;
      ov_q <= 1'b0;
      n_q <= '0;
      lim_q <= '0;
      cmd_q <= alcr_pkg::CmdDispatch;
      pc_q <= '0;
      fresh_q <= '0;
      fault_q <= 1'b0;
      val_q <= '0;
      res_q <= '0;
    end else begin
      st_q <= st_d;
      occ_q <= occ_d;
      exc_q <= exc_d;
      ov_q <= ov_d;
      n_q <= n_d;
      lim_q <= lim_d;
      cmd_q <= cmd_d;
      pc_q <= pc_d;
      fresh_q <= fresh_d;
      fault_q <= fault_d;
      val_q <= val_d;
      res_q <= res_d;
    end
  end

  logic exc_beat;
  assign exc_beat = ov_q && res_q.kind == alcr_pkg::KindExc;

  `ALCR_ASSERT(a_occ_max, clk_i, rst_ni, (32'(occ_q) <= LIST_DEPTH), "occupancy over depth")
  `ALCR_ASSERT(a_no_acc_busy, clk_i, rst_ni, (acc |-> st_q == StIdle), "item taken while busy")
  `ALCR_ASSERT(a_exc_beat, clk_i, rst_ni, (exc_beat |-> exc_q), "exception beat outside mode")
endmodule

// File: verif/active_list_commit_rollback_tb.sv
// Self-checking testbench for the active list: directed table, then random traffic.
module active_list_commit_rollback_tb;

  // One input beat and one result beat as they cross the channels.
  typedef struct packed {
    logic [1:0]                command;
    logic [alcr_pkg::PcW-1:0]  instr_pc;
    logic [4:0]                logical_dest;
    logic [5:0]                prior_phys;
    logic [5:0]                fresh_phys;
    logic                      fault;
    logic [alcr_pkg::ValW-1:0] result_value;
  } cmd_beat_t;

  typedef struct packed {
    logic [alcr_pkg::KindW-1:0] kind;
    logic [5:0]                 phys_reg;
    logic [4:0]                 logical_reg;
    logic [5:0]                 restored_phys;
    logic [alcr_pkg::ValW-1:0]  write_value;
    logic [alcr_pkg::PcW-1:0]   fault_pc;
    logic [alcr_pkg::PcW-1:0]   redirect_pc;
    logic                       last;
  } rob_beat_t;

  typedef struct {
    cmd_beat_t                  beat;
    bit                         known;
    logic [alcr_pkg::KindW-1:0] kind;
  } table_row_t;

  localparam int Depth = 32;
  localparam logic [2:0] AddrLimit = 3'd0;
  localparam logic [2:0] AddrVector = 3'd4;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  alcr_if #(.payload_t(cmd_beat_t)) cmd_ch ();
  alcr_if #(.payload_t(rob_beat_t)) rob_ch ();

  active_list_commit_rollback DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_if(cmd_ch.sink), .out_if(rob_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk_i = ~clk_i;

  // Shadow copy of the list and its registers.
  logic [alcr_pkg::PcW-1:0] sh_pc [Depth];
  logic [4:0] sh_logical [Depth];
  logic [5:0] sh_prior [Depth];
  logic [5:0] sh_fresh [Depth];
  bit sh_done [Depth];
  bit sh_fault [Depth];
  logic [4:0] sh_head;
  int sh_occ;
  bit sh_exc;
  logic [2:0] sh_limit;
  logic [alcr_pkg::PcW-1:0] sh_vector;

  rob_beat_t pending_results[$];
  logic [alcr_pkg::PcW-1:0] pc_pool[$];
  table_row_t rows[$];
  logic [alcr_pkg::KindW-1:0] first_kind;
  int fails = 0;
  int burst_left = 0;
  bit pressure_go = 1'b0;
  bit no_gaps = 1'b0;

  function automatic rob_beat_t blank(logic [alcr_pkg::KindW-1:0] k);
    rob_beat_t r;
    r = '0;
    r.kind = k;
    return r;
  endfunction

  function automatic cmd_beat_t mk_beat(logic [1:0] c, logic [31:0] pc, logic [4:0] ld,
                                        logic [5:0] pp, logic [5:0] fp, logic flt,
                                        logic [63:0] v);
    cmd_beat_t b;
    b.command = c; b.instr_pc = pc; b.logical_dest = ld;
    b.prior_phys = pp; b.fresh_phys = fp; b.fault = flt; b.result_value = v;
    return b;
  endfunction

  // Append one row to the directed table.
  function automatic void add_row(cmd_beat_t b, bit known,
                                  logic [alcr_pkg::KindW-1:0] kind);
    table_row_t r;
    r.beat = b;
    r.known = known;
    r.kind = kind;
    rows.insert(rows.size(), r);
  endfunction

  // Work out the results of one accepted command and update the shadow list.
  function automatic void predict_results(cmd_beat_t b);
    rob_beat_t batch[$];
    rob_beat_t r;
    int lim;
    logic [4:0] s;
    bit hit;
    lim = sh_limit;
    if (lim < 1) lim = 1;
    if (lim > 4) lim = 4;
    hit = 1'b0;
    case (b.command)
      alcr_pkg::CmdDispatch: begin
        if (sh_exc) begin
          batch.insert(batch.size(), blank(alcr_pkg::KindMisuse));
        end else if (sh_occ >= Depth) begin
          batch.insert(batch.size(), blank(alcr_pkg::KindFull));
        end else begin
          s = sh_head + 5'(sh_occ);
          sh_pc[s] = b.instr_pc; sh_logical[s] = b.logical_dest;
          sh_prior[s] = b.prior_phys; sh_fresh[s] = b.fresh_phys;
          sh_done[s] = 1'b0; sh_fault[s] = 1'b0;
          sh_occ++;
          pc_pool.insert(pc_pool.size(), b.instr_pc);
          if (pc_pool.size() > 8) pc_pool.delete(0);
          batch.insert(batch.size(), blank(alcr_pkg::KindNone));
        end
      end
      alcr_pkg::CmdForward: begin
        for (int i = 0; i < sh_occ; i++) begin
          s = sh_head + 5'(i);
          if (sh_pc[s] == b.instr_pc) begin
            sh_done[s] = 1'b1;
            sh_fault[s] = b.fault;
            hit = 1'b1;
          end
        end
        if (hit && !b.fault) begin
          r = blank(alcr_pkg::KindWrite);
          r.phys_reg = b.fresh_phys;
          r.write_value = b.result_value;
          batch.insert(batch.size(), r);
        end else begin
          batch.insert(batch.size(), blank(alcr_pkg::KindNone));
        end
      end
      alcr_pkg::CmdCommit: begin
        if (sh_exc) begin
          batch.insert(batch.size(), blank(alcr_pkg::KindMisuse));
        end else begin
          while (batch.size() < lim && sh_occ > 0) begin
            s = sh_head;
            if (!sh_done[s]) break;
            if (sh_fault[s]) begin
              sh_exc = 1'b1;
              r = blank(alcr_pkg::KindExc);
              r.fault_pc = sh_pc[s];
              r.redirect_pc = sh_vector;
              batch.insert(batch.size(), r);
              break;
            end
            r = blank(alcr_pkg::KindFree);
            r.phys_reg = sh_prior[s];
            batch.insert(batch.size(), r);
            sh_head = sh_head + 5'd1;
            sh_occ--;
          end
          if (batch.size() == 0) batch.insert(batch.size(), blank(alcr_pkg::KindNone));
        end
      end
      default: begin
        if (!sh_exc) begin
          batch.insert(batch.size(), blank(alcr_pkg::KindMisuse));
        end else if (sh_occ == 0) begin
          sh_exc = 1'b0;
          batch.insert(batch.size(), blank(alcr_pkg::KindExcClr));
        end else begin
          while (batch.size() < lim && sh_occ > 0) begin
            s = sh_head + 5'(sh_occ - 1);
            r = blank(alcr_pkg::KindRestore);
            r.phys_reg = sh_fresh[s];
            r.logical_reg = sh_logical[s];
            r.restored_phys = sh_prior[s];
            batch.insert(batch.size(), r);
            sh_occ--;
          end
        end
      end
    endcase
    batch[batch.size()-1].last = 1'b1;
    first_kind = batch[0].kind;
    foreach (batch[i]) pending_results.insert(pending_results.size(), batch[i]);
  endfunction

  // Offer one beat, hold it until accepted, then predict and perhaps pause.
  task automatic send_beat(cmd_beat_t b);
    cmd_ch.valid <= 1'b1;
    cmd_ch.data <= b;
    do @(posedge clk_i); while (!cmd_ch.ready);
    predict_results(b);
    if (burst_left > 0) begin
      burst_left--;
    end else if (!no_gaps) begin
      burst_left = $urandom_range(0, 7);
      if ($urandom_range(0, 1)) begin
        cmd_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  endtask

  // Register write with a setup phase, then an access phase; the register takes the value at the access edge.
  task automatic reg_write(logic [2:0] a, logic [31:0] d);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (a == AddrLimit) sh_limit = d[2:0];
    else sh_vector = d;
  endtask

  // Let every expected beat drain, then let the sequencer settle.
  task automatic drain;
    cmd_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // Random command, mostly well-formed traffic around recently dispatched pcs.
  function automatic cmd_beat_t random_beat();
    cmd_beat_t b;
    int r;
    b = mk_beat(alcr_pkg::CmdDispatch, $urandom(), 5'($urandom()), 6'($urandom()),
                6'($urandom()), 1'b0, {$urandom(), $urandom()});
    r = $urandom_range(0, 99);
    if (sh_exc && r < 60) r = 90;
    if (r < 32) begin
      b.command = alcr_pkg::CmdDispatch;
      if (pc_pool.size() != 0 && $urandom_range(0, 4) == 0)
        b.instr_pc = pc_pool[$urandom_range(0, pc_pool.size() - 1)];
    end else if (r < 62) begin
      b.command = alcr_pkg::CmdForward;
      if (pc_pool.size() != 0 && $urandom_range(0, 5) != 0)
        b.instr_pc = pc_pool[$urandom_range(0, pc_pool.size() - 1)];
      b.fault = ($urandom_range(0, 9) == 0);
    end else if (r < 85) begin
      b.command = alcr_pkg::CmdCommit;
    end else if (r < 95) begin
      b.command = alcr_pkg::CmdRollback;
    end else begin
      b.command = 2'($urandom());
      b.fault = 1'($urandom());
    end
    return b;
  endfunction

  // Receiver: stretches of random stalls, stretches without, and one long hold-off.
  int rx_cycle = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk_i) begin
    rx_cycle++;
    if (!rst_ni) begin
      rob_ch.ready <= 1'b0;
    end else begin
      if (pressure_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        rob_ch.ready <= 1'b0;
      end else if ((rx_cycle / 60) % 3 == 2) begin
        rob_ch.ready <= 1'b1;
      end else begin
        rob_ch.ready <= ($urandom_range(0, 2) != 0);
      end
    end
  end

  // Result checker against the oldest expectation.
  always @(posedge clk_i) begin
    rob_beat_t e;
    if (rst_ni && rob_ch.valid && rob_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: kind %0d", rob_ch.data.kind);
        fails++;
      end else begin
        e = pending_results[0];
        pending_results.delete(0);
        if (rob_ch.data.kind !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, rob_ch.data.kind); fails++;
        end
        if (rob_ch.data.phys_reg !== e.phys_reg) begin
          $error("phys_reg: expected %0d, got %0d", e.phys_reg, rob_ch.data.phys_reg);
          fails++;
        end
        if (rob_ch.data.logical_reg !== e.logical_reg) begin
          $error("logical_reg: expected %0d, got %0d", e.logical_reg,
                 rob_ch.data.logical_reg);
          fails++;
        end
        if (rob_ch.data.restored_phys !== e.restored_phys) begin
          $error("restored_phys: expected %0d, got %0d", e.restored_phys,
                 rob_ch.data.restored_phys);
          fails++;
        end
        if (rob_ch.data.write_value !== e.write_value) begin
          $error("write_value: expected %h, got %h", e.write_value,
                 rob_ch.data.write_value);
          fails++;
        end
        if (rob_ch.data.fault_pc !== e.fault_pc) begin
          $error("fault_pc: expected %h, got %h", e.fault_pc, rob_ch.data.fault_pc);
          fails++;
        end
        if (rob_ch.data.redirect_pc !== e.redirect_pc) begin
          $error("redirect_pc: expected %h, got %h", e.redirect_pc,
                 rob_ch.data.redirect_pc);
          fails++;
        end
        if (rob_ch.data.last !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, rob_ch.data.last); fails++;
        end
      end
    end
  end

  // Watchdog for a hung run.
  initial begin
    #400000;
    $display("[active_list_commit_rollback] ERROR");
    $finish;
  end

  // Main sequence: reset, directed table, then random phases over several settings.
  initial begin
    logic [2:0] limits[6];
    logic [31:0] vectors[6];
    cmd_ch.valid = 1'b0;
    cmd_ch.data = '0;
    sh_head = '0; sh_occ = 0; sh_exc = 1'b0; sh_limit = 3'd4; sh_vector = '0;
    foreach (sh_pc[i]) begin
      sh_pc[i] = '0; sh_logical[i] = '0; sh_prior[i] = '0; sh_fresh[i] = '0;
      sh_done[i] = 1'b0; sh_fault[i] = 1'b0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(mk_beat(alcr_pkg::CmdCommit, '0, '0, '0, '0, 1'b0, '0), 1'b1,
            alcr_pkg::KindNone);
    add_row(mk_beat(alcr_pkg::CmdRollback, '0, '0, '0, '0, 1'b0, '0), 1'b1,
            alcr_pkg::KindMisuse);
    add_row(mk_beat(alcr_pkg::CmdDispatch, '0, '0, '0, '0, 1'b0, '0), 1'b1,
            alcr_pkg::KindNone);
    add_row(mk_beat(alcr_pkg::CmdDispatch, '1, 5'd31, 6'd63, 6'd63, 1'b0, '0), 1'b1,
            alcr_pkg::KindNone);
    add_row(mk_beat(alcr_pkg::CmdForward, '1, '0, '0, 6'd63, 1'b0, '1), 1'b1,
            alcr_pkg::KindWrite);
    add_row(mk_beat(alcr_pkg::CmdForward, '0, '0, '0, '0, 1'b0, '0), 1'b1,
            alcr_pkg::KindWrite);
    add_row(mk_beat(alcr_pkg::CmdForward, 32'h1234, '0, '0, 6'd5, 1'b0, 64'h55), 1'b1,
            alcr_pkg::KindNone);
    add_row(mk_beat(alcr_pkg::CmdCommit, '0, '0, '0, '0, 1'b0, '0), 1'b1,
            alcr_pkg::KindFree);
    add_row(mk_beat(alcr_pkg::CmdDispatch, 32'h100, 5'd3, 6'd10, 6'd11, 1'b0, '0), 1'b1,
            alcr_pkg::KindNone);
    add_row(mk_beat(alcr_pkg::CmdDispatch, 32'h104, 5'd4, 6'd12, 6'd13, 1'b0, '0), 1'b1,
            alcr_pkg::KindNone);
    add_row(mk_beat(alcr_pkg::CmdDispatch, 32'h108, 5'd5, 6'd14, 6'd15, 1'b0, '0), 1'b1,
            alcr_pkg::KindNone);
    add_row(mk_beat(alcr_pkg::CmdCommit, '0, '0, '0, '0, 1'b0, '0), 1'b1,
            alcr_pkg::KindNone);
    add_row(mk_beat(alcr_pkg::CmdForward, 32'h104, '0, '0, 6'd13, 1'b1, '1), 1'b1,
            alcr_pkg::KindNone);
    add_row(mk_beat(alcr_pkg::CmdForward, 32'h100, '0, '0, 6'd11, 1'b0, 64'hA5), 1'b1,
            alcr_pkg::KindWrite);
    add_row(mk_beat(alcr_pkg::CmdCommit, '0, '0, '0, '0, 1'b0, '0), 1'b0,
            alcr_pkg::KindNone);
    add_row(mk_beat(alcr_pkg::CmdDispatch, 32'h10C, 5'd6, 6'd1, 6'd2, 1'b0, '0), 1'b1,
            alcr_pkg::KindMisuse);
    add_row(mk_beat(alcr_pkg::CmdCommit, '0, '0, '0, '0, 1'b0, '0), 1'b1,
            alcr_pkg::KindMisuse);
    add_row(mk_beat(alcr_pkg::CmdRollback, '0, '0, '0, '0, 1'b0, '0), 1'b1,
            alcr_pkg::KindRestore);
    add_row(mk_beat(alcr_pkg::CmdRollback, '0, '0, '0, '0, 1'b0, '0), 1'b1,
            alcr_pkg::KindExcClr);
    add_row(mk_beat(alcr_pkg::CmdForward, 32'h104, '0, '0, '0, 1'b1, '0), 1'b1,
            alcr_pkg::KindNone);

    reg_write(AddrVector, 32'hFFFF_FFFF);
    foreach (rows[i]) begin
      send_beat(rows[i].beat);
      if (rows[i].known && first_kind !== rows[i].kind) begin
        $error("kind: expected %0d, got %0d (table row %0d)", rows[i].kind,
               first_kind, i);
        fails++;
      end
    end
    drain();

    // Fill the list past full while the receiver holds off.
    no_gaps = 1'b1;
    pressure_go = 1'b1;
    for (int i = 0; i < 36; i++)
      send_beat(mk_beat(alcr_pkg::CmdDispatch, 32'h2000 + 4 * i, 5'($urandom()),
                        6'($urandom()), 6'($urandom()), 1'b0, '0));
    no_gaps = 1'b0;
    for (int i = 0; i < 12; i++) send_beat(random_beat());
    drain();

    limits = '{3'd1, 3'd2, 3'd3, 3'd0, 3'd7, 3'd4};
    vectors = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h1C, 32'h0};
    vectors[4] = $urandom();
    foreach (limits[p]) begin
      reg_write(AddrLimit, {29'd0, limits[p]});
      reg_write(AddrVector, vectors[p]);
      for (int i = 0; i < 26; i++) send_beat(random_beat());
      drain();
    end

    if (fails == 0) begin
      $display("[active_list_commit_rollback] OK");
    end else begin
      $display("[active_list_commit_rollback] ERROR");
    end
    $finish;
  end
endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/alcr_pkg.sv
rtl/core/alcr_if.sv
rtl/core/alcr_cell.sv
rtl/core/active_list_commit_rollback.sv
verif/active_list_commit_rollback_tb.sv
